@@ rtl/e2q_pkg.sv @@
package e2q_pkg;

    // Field widths
    localparam int ANGLE_WIDTH = 16;
    localparam int OUT_WIDTH   = 16;

    // Q2.30 working format
    localparam int                 Q_FRAC = 30;
    localparam logic [31:0]        Q_ONE  = 32'd1 << Q_FRAC;
    localparam logic [63:0]        PI_Q30 = 64'd3373259426;
    localparam int                 OUT_SH = 32 - OUT_WIDTH;
    localparam logic [32:0]        OUT_LIM = 33'd1 << (OUT_WIDTH - 2);

    // Horner divisors and their reciprocals, floor(2^32 / d)
    localparam logic [31:0] SIN_DIV0   = 32'd72;
    localparam logic [31:0] COS_DIV0   = 32'd90;
    localparam logic [31:0] SIN_RCP0   = 32'((64'd1 << 32) / 72);
    localparam logic [31:0] COS_RCP0   = 32'((64'd1 << 32) / 90);
    localparam logic [31:0] SIN_DIV[3] = '{32'd42, 32'd20, 32'd6};
    localparam logic [31:0] COS_DIV[3] = '{32'd56, 32'd30, 32'd12};
    localparam logic [31:0] SIN_RCP[3] = '{32'((64'd1 << 32) / 42),
                                           32'((64'd1 << 32) / 20),
                                           32'((64'd1 << 32) / 6)};
    localparam logic [31:0] COS_RCP[3] = '{32'((64'd1 << 32) / 56),
                                           32'((64'd1 << 32) / 30),
                                           32'((64'd1 << 32) / 12)};

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] roll_angle;
        logic signed [ANGLE_WIDTH-1:0] pitch_angle;
        logic signed [ANGLE_WIDTH-1:0] yaw_angle;
    } t_angles;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] quat_w;
        logic signed [OUT_WIDTH-1:0] quat_x;
        logic signed [OUT_WIDTH-1:0] quat_y;
        logic signed [OUT_WIDTH-1:0] quat_z;
    } t_quat;

    // Half-angle magnitude in Q2.30 from binary angle magnitude
    function automatic logic [31:0] half_rad(input logic [ANGLE_WIDTH:0] mag);
        logic [63:0] p;
        p = 64'(mag) * PI_Q30 + (64'd1 << (ANGLE_WIDTH - 1));
        return 32'(p >> ANGLE_WIDTH);
    endfunction

    // Unsigned Q2.30 product, rounded
    function automatic logic [31:0] umulq(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b) + (64'd1 << (Q_FRAC - 1));
        return 32'(p >> Q_FRAC);
    endfunction

    // Reciprocal estimate, low by at most one
    function automatic logic [31:0] rcp_est(input logic [31:0] v, input logic [31:0] m);
        logic [63:0] p;
        p = 64'(v) * 64'(m);
        return p[63:32];
    endfunction

    // Quotient correction
    function automatic logic [31:0] rcp_fix(input logic [31:0] v, input logic [31:0] q0,
                                            input logic [31:0] d);
        logic [63:0] r;
        r = 64'(v) - 64'(q0) * 64'(d);
        return (r >= 64'(d)) ? q0 + 32'd1 : q0;
    endfunction

    function automatic logic [31:0] one_minus(input logic [31:0] v);
        return (v >= Q_ONE) ? 32'd0 : Q_ONE - v;
    endfunction

    // Signed Q2.30 product, rounded half away from zero
    function automatic logic signed [31:0] smulq(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic        neg;
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] m;
        neg = a[31] ^ b[31];
        ua  = a[31] ? 32'(-a) : 32'(a);
        ub  = b[31] ? 32'(-b) : 32'(b);
        m   = umulq(ua, ub);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // Q2.30 to output format, rounded and saturated
    function automatic logic [OUT_WIDTH-1:0] to_out(input logic signed [32:0] v);
        logic        neg;
        logic [32:0] mag;
        logic [32:0] r;
        neg = v[32];
        mag = neg ? 33'(-v) : 33'(v);
        mag = (mag + (33'd1 << (OUT_SH - 1))) >> OUT_SH;
        if (mag > OUT_LIM) begin
            mag = OUT_LIM;
        end
        r = neg ? 33'(-mag) : mag;
        return r[OUT_WIDTH-1:0];
    endfunction

endpackage

@@ rtl/e2q_half_trig.sv @@
module e2q_half_trig
    import e2q_pkg::*;
(
    input  logic                    i_clk,
    input  logic [ANGLE_WIDTH-1:0]  i_angle,
    output logic signed [31:0]      o_cos,
    output logic signed [31:0]      o_sin
);

    // Sixteen register stages, fixed latency, free running
    localparam int NS = 15;

    logic                 r_neg  [NS];
    logic [31:0]          r_x    [NS];
    logic [31:0]          r_x2   [NS];
    logic [ANGLE_WIDTH:0] r_mag;
    logic [31:0]          r_qs0, r_qc0;
    logic [31:0]          r_ts   [4];
    logic [31:0]          r_tc   [4];
    logic [31:0]          r_ps   [3];
    logic [31:0]          r_pc   [3];
    logic [31:0]          r_ps2  [3];
    logic [31:0]          r_pc2  [3];
    logic [31:0]          r_qs   [3];
    logic [31:0]          r_qc   [3];
    logic [31:0]          r_sp, r_cp;
    logic signed [31:0]   r_sin, r_cos;
    logic [31:0]          n_sn;
    logic signed [ANGLE_WIDTH:0] n_sv;

    assign n_sv = {i_angle[ANGLE_WIDTH-1], i_angle};

    // Sine clamp to one
    assign n_sn = (r_sp > Q_ONE) ? Q_ONE : r_sp;

    always_ff @(posedge i_clk) begin
        // stage 0: sign and magnitude
        r_neg[0] <= i_angle[ANGLE_WIDTH-1];
        r_mag    <= i_angle[ANGLE_WIDTH-1] ? (ANGLE_WIDTH+1)'(-n_sv)
                                           : (ANGLE_WIDTH+1)'(n_sv);
        // stage 1: half angle in radians
        r_x[1]   <= half_rad(r_mag);
        // stage 2: square
        r_x2[2]  <= umulq(r_x[1], r_x[1]);
        // carry lines
        for (int i = 1; i < NS; i++) begin
            r_neg[i] <= r_neg[i-1];
        end
        for (int i = 2; i < NS; i++) begin
            r_x[i] <= r_x[i-1];
        end
        for (int i = 3; i < NS; i++) begin
            r_x2[i] <= r_x2[i-1];
        end
        // stages 3-4: first Horner term
        r_qs0   <= rcp_est(r_x2[2], SIN_RCP0);
        r_qc0   <= rcp_est(r_x2[2], COS_RCP0);
        r_ts[0] <= one_minus(rcp_fix(r_x2[3], r_qs0, SIN_DIV0));
        r_tc[0] <= one_minus(rcp_fix(r_x2[3], r_qc0, COS_DIV0));
        // stages 5-13: three Horner steps, three stages each
        for (int k = 0; k < 3; k++) begin
            r_ps[k]   <= umulq(r_x2[4 + 3*k], r_ts[k]);
            r_pc[k]   <= umulq(r_x2[4 + 3*k], r_tc[k]);
            r_qs[k]   <= rcp_est(r_ps[k], SIN_RCP[k]);
            r_qc[k]   <= rcp_est(r_pc[k], COS_RCP[k]);
            r_ps2[k]  <= r_ps[k];
            r_pc2[k]  <= r_pc[k];
            r_ts[k+1] <= one_minus(rcp_fix(r_ps2[k], r_qs[k], SIN_DIV[k]));
            r_tc[k+1] <= one_minus(rcp_fix(r_pc2[k], r_qc[k], COS_DIV[k]));
        end
        // stage 14: final products
        r_sp <= umulq(r_x[13], r_ts[3]);
        r_cp <= umulq(r_x2[13], r_tc[3]);
        // stage 15: sign, last cosine term
        r_sin <= r_neg[14] ? -$signed(n_sn) : $signed(n_sn);
        r_cos <= $signed(one_minus(r_cp >> 1));
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

@@ rtl/euler_to_quaternion_core.sv @@
// Channel   | Ports                          | Transaction
// ----------+--------------------------------+-------------------------------
// angles in | i_start, o_busy, i_angles      | start high while busy low
// quat out  | o_valid, o_quat                | one-cycle strobe on o_valid
//
// Accepts one transaction every cycle; o_busy is always low.
// Results pass first through the half-angle sine/cosine lanes (Horner
// steps, each a product, a reciprocal multiply and a correction), then
// through the quaternion products, the sums and the output rounding.
// Synchronous active-low reset clears the valid line only.
// The receiver cannot stall; the pipeline never holds.
module euler_to_quaternion_core
    import e2q_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_angles i_angles,
    output logic    o_busy,
    output logic    o_valid,
    output t_quat   o_quat
);

    localparam int LAT = 19;

    logic               r_vld [LAT];
    logic signed [31:0] cr, sr, cp, sp, cy, sy;
    logic signed [31:0] r_cycp, r_sysp, r_cysp, r_sycp, r_cr, r_sr;
    logic signed [31:0] r_m [8];
    t_quat              r_quat;
    logic               n_acc;

    assign o_busy = 1'b0;
    assign n_acc  = i_start && !o_busy;

    // Half-angle trig lanes
    e2q_half_trig u_roll  (.i_clk(i_clk), .i_angle(i_angles.roll_angle),
                           .o_cos(cr), .o_sin(sr));
    e2q_half_trig u_pitch (.i_clk(i_clk), .i_angle(i_angles.pitch_angle),
                           .o_cos(cp), .o_sin(sp));
    e2q_half_trig u_yaw   (.i_clk(i_clk), .i_angle(i_angles.yaw_angle),
                           .o_cos(cy), .o_sin(sy));

    // Valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= n_acc;
            for (int i = 1; i < LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // Quaternion products and sums
    always_ff @(posedge i_clk) begin
        r_cycp <= smulq(cy, cp);
        r_sysp <= smulq(sy, sp);
        r_cysp <= smulq(cy, sp);
        r_sycp <= smulq(sy, cp);
        r_cr   <= cr;
        r_sr   <= sr;
        r_m[0] <= smulq(r_cycp, r_cr);
        r_m[1] <= smulq(r_sysp, r_sr);
        r_m[2] <= smulq(r_cycp, r_sr);
        r_m[3] <= smulq(r_sysp, r_cr);
        r_m[4] <= smulq(r_cysp, r_cr);
        r_m[5] <= smulq(r_sycp, r_sr);
        r_m[6] <= smulq(r_sycp, r_cr);
        r_m[7] <= smulq(r_cysp, r_sr);
        r_quat.quat_w <= to_out(33'(r_m[0]) + 33'(r_m[1]));
        r_quat.quat_x <= to_out(33'(r_m[2]) - 33'(r_m[3]));
        r_quat.quat_y <= to_out(33'(r_m[4]) + 33'(r_m[5]));
        r_quat.quat_z <= to_out(33'(r_m[6]) - 33'(r_m[7]));
    end

    assign o_valid = r_vld[LAT-1];
    assign o_quat  = r_quat;

    // Checks
    a_no_busy: assert property (@(posedge i_clk) !o_busy)
        else $error("busy raised");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(n_acc, LAT))
        else $error("result without transaction");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_quat.quat_w <= 16'sd16384 && o_quat.quat_w >= -16'sd16384 &&
                     o_quat.quat_x <= 16'sd16384 && o_quat.quat_x >= -16'sd16384 &&
                     o_quat.quat_y <= 16'sd16384 && o_quat.quat_y >= -16'sd16384 &&
                     o_quat.quat_z <= 16'sd16384 && o_quat.quat_z >= -16'sd16384))
        else $error("component out of range");

endmodule
